FILE: hw/rtl/bgpg_pkg.sv
// Shared types and constants for the bilinear gradient pattern generator.
// No dependencies; every other file in hw/rtl imports this package.
package bgpg_pkg;

    localparam int MAX_DIM_DEF     = 4096;
    localparam int WEIGHT_BITS_DEF = 16;

    localparam int DIM_REG_W  = 13;
    localparam int COLOR_W    = 48;
    localparam int CH_W       = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int FIFO_DEPTH = 4;

    localparam logic [DIM_REG_W-1:0] FRAME_WIDTH_RST  = 13'd640;
    localparam logic [DIM_REG_W-1:0] FRAME_HEIGHT_RST = 13'd480;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_PIXEL_FORMAT = 3'd2,
        REG_CORNER_A     = 3'd3,
        REG_CORNER_B     = 3'd4,
        REG_CORNER_C     = 3'd5,
        REG_CORNER_D     = 3'd6
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CH_RED,
        CH_GREEN,
        CH_BLUE
    } chan_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_DIV,
        B_FEED,
        B_DRAIN,
        B_DONE
    } back_state_t;

    typedef struct packed {
        logic               pixel_format;
        logic [COLOR_W-1:0] corner_a;
        logic [COLOR_W-1:0] corner_b;
        logic [COLOR_W-1:0] corner_c;
        logic [COLOR_W-1:0] corner_d;
    } color_cfg_t;

endpackage

FILE: hw/rtl/bilinear_gradient_pattern_generator_unit.sv
// Top level of the bilinear gradient pattern generator: configuration
// registers, raster front end, descriptor queue and blend back end.
// Depends on bgpg_pkg, bgpg_fifo, bgpg_front, bgpg_back (and bgpg_div).

// Every input transfer emits one pixel of a row-major test frame; restart=1
// makes that pixel (0,0). The pixel is a bilinear blend of four corner colors
// with WEIGHT_BITS-bit weights x*2^WB/(width-1) and y*2^WB/(height-1),
// truncated; last_of_frame marks the bottom-right pixel. Widths and heights of
// 0 act as 1 and values above MAX_DIM as MAX_DIM. The front end accepts a
// transfer per cycle until its FIFO_DEPTH-entry queue fills; the back end
// finishes one pixel before it takes the next from the queue,
// paced by the bit-serial weight dividers followed by the shared
// four-stage multiply pipeline that runs the three channels in turn.
// Configuration writes take effect at once and belong in idle periods.
module bilinear_gradient_pattern_generator_unit import bgpg_pkg::*; #(
    parameter int MAX_DIM     = MAX_DIM_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_restart,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [CH_W-1:0]       m_red,
    output logic [CH_W-1:0]       m_green,
    output logic [CH_W-1:0]       m_blue,
    output logic                  m_last_of_frame
);

    localparam int POS_W   = $clog2(MAX_DIM);
    localparam int ENTRY_W = 4 * POS_W + 1;

    logic [DIM_REG_W-1:0] frame_width_reg;
    logic [DIM_REG_W-1:0] frame_height_reg;
    color_cfg_t           color_cfg_reg;

    logic               fifo_full, fifo_empty;
    logic               push, pop;
    logic [ENTRY_W-1:0] push_entry, pop_entry;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            color_cfg_reg    <= '0;
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:  frame_width_reg            <= cfg_wdata[DIM_REG_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg           <= cfg_wdata[DIM_REG_W-1:0];
                REG_PIXEL_FORMAT: color_cfg_reg.pixel_format <= cfg_wdata[0];
                REG_CORNER_A:     color_cfg_reg.corner_a     <= cfg_wdata[COLOR_W-1:0];
                REG_CORNER_B:     color_cfg_reg.corner_b     <= cfg_wdata[COLOR_W-1:0];
                REG_CORNER_C:     color_cfg_reg.corner_c     <= cfg_wdata[COLOR_W-1:0];
                REG_CORNER_D:     color_cfg_reg.corner_d     <= cfg_wdata[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    bgpg_front #(.MAX_DIM(MAX_DIM), .POS_W(POS_W)) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_restart    (s_restart),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .fifo_full    (fifo_full),
        .push         (push),
        .entry        (push_entry)
    );

    bgpg_fifo #(.WIDTH(ENTRY_W), .DEPTH(FIFO_DEPTH)) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .din     (push_entry),
        .full    (fifo_full),
        .pop     (pop),
        .dout    (pop_entry),
        .empty   (fifo_empty)
    );

    bgpg_back #(.WB(WEIGHT_BITS), .POS_W(POS_W)) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .color_cfg       (color_cfg_reg),
        .fifo_empty      (fifo_empty),
        .entry           (pop_entry),
        .pop             (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_red           (m_red),
        .m_green         (m_green),
        .m_blue          (m_blue),
        .m_last_of_frame (m_last_of_frame)
    );

endmodule

FILE: hw/rtl/bgpg_fifo.sv
// Small register queue between the raster front end and the blend back end.
// Depends on bgpg_pkg (depth default).
module bgpg_fifo import bgpg_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = FIFO_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

FILE: hw/rtl/bgpg_div.sv
// Bit-serial restoring divider for one blend weight: floor(pos * 2^WB / divisor).
// Depends on bgpg_pkg. pos never exceeds divisor, so the quotient has WB+1 bits.
module bgpg_div import bgpg_pkg::*; #(
    parameter int POS_W = 12,
    parameter int WB    = WEIGHT_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [POS_W-1:0] pos,
    input  logic [POS_W-1:0] divisor,
    output logic             busy,
    output logic [WB:0]      quot
);

    localparam int CNT_W = $clog2(WB + 1);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [POS_W:0]   rem_reg, rem_next;
    logic [POS_W-1:0] div_reg, div_next;
    logic             qtop_reg, qtop_next;
    logic [WB-1:0]    qlow_reg, qlow_next;
    logic [POS_W:0]   rem_sh;
    logic             ge;

    assign busy = busy_reg;
    assign quot = {qtop_reg, qlow_reg};

    always_comb begin
        rem_sh    = {rem_reg[POS_W-1:0], 1'b0};
        ge        = (rem_sh >= {1'b0, div_reg});
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        qtop_next = qtop_reg;
        qlow_next = qlow_reg;
        if (start) begin
            div_next  = divisor;
            qlow_next = '0;
            cnt_next  = CNT_W'(WB);
            if (divisor == '0) begin
                // single row or column: weight is zero
                busy_next = 1'b0;
                qtop_next = 1'b0;
                rem_next  = '0;
            end else begin
                busy_next = 1'b1;
                // integer part is 0 or 1 since pos <= divisor
                if (pos >= divisor) begin
                    qtop_next = 1'b1;
                    rem_next  = (POS_W + 1)'(pos - divisor);
                end else begin
                    qtop_next = 1'b0;
                    rem_next  = {1'b0, pos};
                end
            end
        end else if (busy_reg) begin
            rem_next  = ge ? (rem_sh - {1'b0, div_reg}) : rem_sh;
            qlow_next = {qlow_reg[WB-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        qtop_reg <= qtop_next;
        qlow_reg <= qlow_next;
    end

endmodule

FILE: hw/rtl/bgpg_front.sv
// Raster front end: takes restart ticks, steps the column/row counters and
// queues one pixel descriptor per transfer. Depends on bgpg_pkg.
module bgpg_front import bgpg_pkg::*; #(
    parameter int MAX_DIM = MAX_DIM_DEF,
    parameter int POS_W   = $clog2(MAX_DIM)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_restart,
    input  logic [DIM_REG_W-1:0] frame_width,
    input  logic [DIM_REG_W-1:0] frame_height,
    input  logic                 fifo_full,
    output logic                 push,
    output logic [4*POS_W:0]     entry
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int CMP_W = (DIM_W > DIM_REG_W) ? DIM_W : DIM_REG_W;

    logic [POS_W-1:0] col_reg, col_next;
    logic [POS_W-1:0] row_reg, row_next;
    logic [CMP_W-1:0] w_wide, h_wide;
    logic [DIM_W-1:0] w_eff, h_eff;
    logic [DIM_W-1:0] wm1, hm1;
    logic [POS_W-1:0] col_cur, row_cur;
    logic [DIM_W-1:0] col_inc, row_inc;
    logic             last;

    assign s_ready = !fifo_full;
    assign push    = s_valid && s_ready;

    always_comb begin
        // clamp the dimension registers to 1..MAX_DIM
        w_wide = CMP_W'(frame_width);
        h_wide = CMP_W'(frame_height);
        if (w_wide == '0) begin
            w_wide = CMP_W'(1);
        end else if (w_wide > CMP_W'(MAX_DIM)) begin
            w_wide = CMP_W'(MAX_DIM);
        end
        if (h_wide == '0) begin
            h_wide = CMP_W'(1);
        end else if (h_wide > CMP_W'(MAX_DIM)) begin
            h_wide = CMP_W'(MAX_DIM);
        end
        w_eff = w_wide[DIM_W-1:0];
        h_eff = h_wide[DIM_W-1:0];
        wm1   = w_eff - DIM_W'(1);
        hm1   = h_eff - DIM_W'(1);

        col_cur = s_restart ? '0 : col_reg;
        row_cur = s_restart ? '0 : row_reg;
        // dimensions may have shrunk since the last pixel
        if (DIM_W'(col_cur) >= w_eff) begin
            col_cur = '0;
        end
        if (DIM_W'(row_cur) >= h_eff) begin
            row_cur = '0;
        end
        last = (DIM_W'(col_cur) == wm1) && (DIM_W'(row_cur) == hm1);

        col_inc  = DIM_W'(col_cur) + DIM_W'(1);
        row_inc  = DIM_W'(row_cur) + DIM_W'(1);
        col_next = col_inc[POS_W-1:0];
        row_next = row_cur;
        if (col_inc >= w_eff) begin
            col_next = '0;
            row_next = (row_inc >= h_eff) ? '0 : row_inc[POS_W-1:0];
        end

        entry = {last, hm1[POS_W-1:0], wm1[POS_W-1:0], row_cur, col_cur};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (push) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

FILE: hw/rtl/bgpg_back.sv
// Blend back end: two serial weight dividers, a four-stage multiply/add
// pipeline shared by the three channels, and the result register.
// Depends on bgpg_pkg and bgpg_div.
module bgpg_back import bgpg_pkg::*; #(
    parameter int WB    = WEIGHT_BITS_DEF,
    parameter int POS_W = 12
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  color_cfg_t       color_cfg,
    input  logic             fifo_empty,
    input  logic [4*POS_W:0] entry,
    output logic             pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [CH_W-1:0]  m_red,
    output logic [CH_W-1:0]  m_green,
    output logic [CH_W-1:0]  m_blue,
    output logic             m_last_of_frame
);

    localparam int WT_W   = WB + 1;
    localparam int PROD_W = CH_W + WT_W;
    localparam int TOP_W  = CH_W + WB;
    localparam int LO_W   = CH_W;
    localparam int PLO_W  = LO_W + WT_W;
    localparam int PHI_W  = WB + WT_W;
    localparam int SUM_W  = CH_W + 2 * WB;
    localparam int NSTG   = 4;
    localparam logic [WT_W-1:0] ONE_W = {1'b1, {WB{1'b0}}};

    back_state_t state_reg, state_next;
    chan_t       feed_ch_reg, feed_ch_next;
    logic        div_start;
    logic        divx_busy, divy_busy;
    logic [WB:0] wx, wy;
    logic [WT_W-1:0] wxn, wyn;
    logic        in_vld;
    logic        out_load;
    logic        last_reg;
    logic [NSTG-1:0] vld_reg, vld_next;
    chan_t       tag_reg [NSTG];
    logic        m_valid_reg, m_valid_next;

    logic [CH_W-1:0]   ca, cb, cc, cd;
    logic [PROD_W-1:0] pa_reg, pb_reg, pc_reg, pd_reg;
    logic [PROD_W-1:0] pa_next, pb_next, pc_next, pd_next;
    logic [TOP_W-1:0]  top_reg, bot_reg, top_next, bot_next;
    logic [PLO_W-1:0]  tlo_reg, blo_reg, tlo_next, blo_next;
    logic [PHI_W-1:0]  thi_reg, bhi_reg, thi_next, bhi_next;
    logic [SUM_W-1:0]  tsum_reg, bsum_reg, tsum_next, bsum_next;
    logic [SUM_W-1:0]  sum_all;
    logic [CH_W-1:0]   res_red_reg, res_green_reg, res_blue_reg;
    logic [CH_W-1:0]   m_red_reg, m_green_reg, m_blue_reg;
    logic              m_last_reg;

    function automatic logic [CH_W-1:0] chan_of(input logic [COLOR_W-1:0] color,
                                                input chan_t ch, input logic fmt16);
        logic [CH_W-1:0] c;
        case (ch)
            CH_RED:   c = color[47:32];
            CH_GREEN: c = color[31:16];
            CH_BLUE:  c = color[15:0];
            default:  c = color[15:0];
        endcase
        if (!fmt16) begin
            c[CH_W-1:8] = '0;
        end
        return c;
    endfunction

    bgpg_div #(.POS_W(POS_W), .WB(WB)) u_div_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .pos     (entry[POS_W-1:0]),
        .divisor (entry[3*POS_W-1:2*POS_W]),
        .busy    (divx_busy),
        .quot    (wx)
    );

    bgpg_div #(.POS_W(POS_W), .WB(WB)) u_div_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .pos     (entry[2*POS_W-1:POS_W]),
        .divisor (entry[4*POS_W-1:3*POS_W]),
        .busy    (divy_busy),
        .quot    (wy)
    );

    // sequencer
    always_comb begin
        state_next   = state_reg;
        feed_ch_next = feed_ch_reg;
        pop          = 1'b0;
        in_vld       = 1'b0;
        out_load     = 1'b0;
        case (state_reg)
            B_IDLE: begin
                if (!fifo_empty) begin
                    pop        = 1'b1;
                    state_next = B_DIV;
                end
            end
            B_DIV: begin
                if (!divx_busy && !divy_busy) begin
                    feed_ch_next = CH_RED;
                    state_next   = B_FEED;
                end
            end
            B_FEED: begin
                in_vld = 1'b1;
                case (feed_ch_reg)
                    CH_RED:   feed_ch_next = CH_GREEN;
                    CH_GREEN: feed_ch_next = CH_BLUE;
                    default: begin
                        feed_ch_next = CH_RED;
                        state_next   = B_DRAIN;
                    end
                endcase
            end
            B_DRAIN: begin
                if (vld_reg == '0) begin
                    state_next = B_DONE;
                end
            end
            B_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    assign div_start    = pop;
    assign vld_next     = {vld_reg[NSTG-2:0], in_vld};
    assign m_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    // blend datapath
    always_comb begin
        wxn = ONE_W - wx;
        wyn = ONE_W - wy;
        ca  = chan_of(color_cfg.corner_a, feed_ch_reg, color_cfg.pixel_format);
        cb  = chan_of(color_cfg.corner_b, feed_ch_reg, color_cfg.pixel_format);
        cc  = chan_of(color_cfg.corner_c, feed_ch_reg, color_cfg.pixel_format);
        cd  = chan_of(color_cfg.corner_d, feed_ch_reg, color_cfg.pixel_format);

        pa_next = PROD_W'(ca) * PROD_W'(wx);
        pb_next = PROD_W'(cb) * PROD_W'(wxn);
        pc_next = PROD_W'(cc) * PROD_W'(wx);
        pd_next = PROD_W'(cd) * PROD_W'(wxn);

        // each row blend stays below 2^(CH_W+WB)
        top_next = TOP_W'(pa_reg + pb_reg);
        bot_next = TOP_W'(pc_reg + pd_reg);

        // second weight multiply split into low and high halves
        tlo_next = PLO_W'(top_reg[LO_W-1:0]) * PLO_W'(wy);
        thi_next = PHI_W'(top_reg[TOP_W-1:LO_W]) * PHI_W'(wy);
        blo_next = PLO_W'(bot_reg[LO_W-1:0]) * PLO_W'(wyn);
        bhi_next = PHI_W'(bot_reg[TOP_W-1:LO_W]) * PHI_W'(wyn);

        tsum_next = SUM_W'(tlo_reg) + (SUM_W'(thi_reg) << LO_W);
        bsum_next = SUM_W'(blo_reg) + (SUM_W'(bhi_reg) << LO_W);

        sum_all = tsum_reg + bsum_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            feed_ch_reg <= CH_RED;
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            feed_ch_reg <= feed_ch_next;
            vld_reg     <= vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pa_reg     <= pa_next;
        pb_reg     <= pb_next;
        pc_reg     <= pc_next;
        pd_reg     <= pd_next;
        top_reg    <= top_next;
        bot_reg    <= bot_next;
        tlo_reg    <= tlo_next;
        thi_reg    <= thi_next;
        blo_reg    <= blo_next;
        bhi_reg    <= bhi_next;
        tsum_reg   <= tsum_next;
        bsum_reg   <= bsum_next;
        tag_reg[0] <= feed_ch_reg;
        for (int i = 1; i < NSTG; i++) begin
            tag_reg[i] <= tag_reg[i-1];
        end
        if (pop) begin
            last_reg <= entry[4*POS_W];
        end
        if (vld_reg[NSTG-1]) begin
            case (tag_reg[NSTG-1])
                CH_RED:   res_red_reg   <= sum_all[SUM_W-1 -: CH_W];
                CH_GREEN: res_green_reg <= sum_all[SUM_W-1 -: CH_W];
                default:  res_blue_reg  <= sum_all[SUM_W-1 -: CH_W];
            endcase
        end
        if (out_load) begin
            m_red_reg   <= res_red_reg;
            m_green_reg <= res_green_reg;
            m_blue_reg  <= res_blue_reg;
            m_last_reg  <= last_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_red           = m_red_reg;
    assign m_green         = m_green_reg;
    assign m_blue          = m_blue_reg;
    assign m_last_of_frame = m_last_reg;

    a_done_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_DONE) |-> (vld_reg == '0))
        else $error("result loaded while blend pipeline still busy");

    a_feed_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_FEED) |-> (!divx_busy && !divy_busy))
        else $error("blend started before weights settled");

    a_weight_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_FEED) |-> ((wx <= ONE_W) && (wy <= ONE_W)))
        else $error("blend weight above one");

    a_valid_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == B_DONE))
        else $error("output valid raised outside result load");

endmodule
